[hw/rtl/page_writeback_cache_controller_defines.svh]
// Assertion macros shared by the page write-back cache controller RTL.
`ifndef PAGE_WRITEBACK_CACHE_CONTROLLER_DEFINES_SVH
`define PAGE_WRITEBACK_CACHE_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define PWCC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pwcc assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PWCC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pwcc assertion failed");

`else

`define PWCC_ASSERT_NOW(label, clk, rstn, ante, cons)
`define PWCC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[hw/rtl/pwcc_pkg.sv]
// Shared types, constants and helpers of the page write-back cache controller.
package pwcc_pkg;

    // Field widths of the request and result items.
    localparam int unsigned OP_W   = 4;
    localparam int unsigned ADDR_W = 16;
    localparam int unsigned SI_W   = 6;
    localparam int unsigned TAG_W  = 10;
    localparam int unsigned AGE_W  = 8;
    localparam int unsigned SLOT_W = 3;

    // Defaults of the top-level parameters.
    localparam int unsigned SLOTS_DEF      = 8;
    localparam int unsigned PAGE_BYTES_DEF = 64;

    // Tag value of an empty slot; pages at or above it are reserved.
    localparam logic [TAG_W-1:0] EMPTY_TAG = 10'h3FF;

    // Reset value of the write-back age limit.
    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 8'd32;

    // Bulk operations report at most this many write-backs.
    localparam int unsigned RES_LIMIT = 8;
    localparam int unsigned RES_CNT_W = $clog2(RES_LIMIT + 1);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ       = 4'd0;
    localparam logic [OP_W-1:0] OP_WRITE      = 4'd1;
    localparam logic [OP_W-1:0] OP_TICK       = 4'd2;
    localparam logic [OP_W-1:0] OP_INV_ADDR   = 4'd3;
    localparam logic [OP_W-1:0] OP_INV_SLOT   = 4'd4;
    localparam logic [OP_W-1:0] OP_AGE_ADDR   = 4'd5;
    localparam logic [OP_W-1:0] OP_AGE_SLOT   = 4'd6;
    localparam logic [OP_W-1:0] OP_FLUSH_SLOT = 4'd7;
    localparam logic [OP_W-1:0] OP_INV_ALL    = 4'd8;
    localparam logic [OP_W-1:0] OP_FLUSH_ALL  = 4'd9;

    // One result item, without the end-of-request mark.
    typedef struct packed {
        logic              status;
        logic              hit;
        logic [SLOT_W-1:0] access_slot;
        logic              fill_valid;
        logic              writeback_valid;
        logic [SLOT_W-1:0] writeback_slot;
        logic [TAG_W-1:0]  writeback_page;
    } res_t;

    localparam res_t RES_NONE    = '{default: '0};
    localparam res_t RES_IGNORED = '{status: 1'b1, default: '0};

    // Result that reports one write-back.
    function automatic res_t res_wb(input logic [SLOT_W-1:0] slot,
                                    input logic [TAG_W-1:0] page);
        res_t r;
        r                 = RES_NONE;
        r.writeback_valid = 1'b1;
        r.writeback_slot  = slot;
        r.writeback_page  = page;
        return r;
    endfunction

endpackage

[hw/rtl/page_writeback_cache_controller.sv]
// Top level of the page write-back cache controller: slot state and sequencer.
//
// Bookkeeping for a small fully associative write-back cache of pages.
// Requests enter on the s_ stream (operation in s_tuser, address and slot
// index in s_tdata); results leave on the m_ stream, with the final result
// of each request marked by m_tlast. The age limit is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while no request is
// in progress, as the block itself does not enforce this. One request is
// handled at a time; s_tready is high only between requests. Slot state
// lives in small memories with a registered read port, and one
// compare/update unit visits the slots one at a time (read, then update).
// Read, write, address invalidate and address age divide the address
// into a page, scan all slots and apply one update step; tick, invalidate
// all and flush all scan the slots; slot operations read and update one
// slot; reserved pages, bad slots and unknown operations skip the scan.
// Bulk operations hand out one result per dirty slot as they scan.
// A result waits in the output register while m_tready is low, and the
// sequencer holds until that register is free; the next request can be
// accepted while the last result still waits there.
// Reset (aresetn low, synchronous) empties all slots, clears ages and dirty
// bits by clearing one valid flag per slot, and sets the age limit to 32.
`include "page_writeback_cache_controller_defines.svh"

module page_writeback_cache_controller #(
    parameter int unsigned SLOTS      = pwcc_pkg::SLOTS_DEF,
    parameter int unsigned PAGE_BYTES = pwcc_pkg::PAGE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // address[15:0], slot_index[21:16], zero[23:22]
    input  logic [3:0]  s_tuser,    // operation[3:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // hit[0], access_slot[3:1], fill_valid[4],
                                    // writeback_valid[5], writeback_slot[8:6],
                                    // writeback_page[18:9], zero[23:19]
    output logic [0:0]  m_tuser,    // status[0]
    output logic        m_tlast,
    // Age limit register.
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    localparam int unsigned ADDR_W = pwcc_pkg::ADDR_W;
    localparam int unsigned TAG_W  = pwcc_pkg::TAG_W;
    localparam int unsigned AGE_W  = pwcc_pkg::AGE_W;
    localparam int unsigned OP_W   = pwcc_pkg::OP_W;
    localparam int unsigned SI_W   = pwcc_pkg::SI_W;
    localparam int unsigned SLOT_W = pwcc_pkg::SLOT_W;
    localparam int unsigned CNT_W  = pwcc_pkg::RES_CNT_W;
    localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Page number by reciprocal multiply: the estimate is exact or one low.
    localparam int unsigned DIV_SH  = ADDR_W + 8;
    localparam int unsigned PROD_W  = ADDR_W + DIV_SH;
    localparam logic [DIV_SH-1:0] RECIP = DIV_SH'((64'd1 << DIV_SH) / PAGE_BYTES);
    localparam logic [ADDR_W-1:0] PAGE_SIZE = ADDR_W'(PAGE_BYTES);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIV   = 7'b0000010,
        ST_CORR  = 7'b0000100,
        ST_RD    = 7'b0001000,
        ST_EX    = 7'b0010000,
        ST_APPLY = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    // Control registers.
    state_t              state_reg, state_next;
    logic [AGE_W-1:0]    max_age_reg, max_age_next;
    logic [SLOTS-1:0]    ent_valid_reg, ent_valid_next;
    logic                held_valid_reg, held_valid_next;
    logic                m_valid_reg, m_valid_next;

    // Request and scan registers.
    logic [OP_W-1:0]     op_reg, op_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   q0_reg, q0_next;
    logic [ADDR_W-1:0]   page_reg, page_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    res_cnt_reg, res_cnt_next;
    logic                hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [AGE_W-1:0]    hit_age_reg, hit_age_next;
    logic                hit_dirty_reg, hit_dirty_next;
    logic                emp_found_reg, emp_found_next;
    logic [IDX_W-1:0]    emp_idx_reg, emp_idx_next;
    logic                cln_found_reg, cln_found_next;
    logic [IDX_W-1:0]    cln_idx_reg, cln_idx_next;
    logic [AGE_W-1:0]    cln_age_reg, cln_age_next;
    logic [TAG_W-1:0]    tag0_reg, tag0_next;
    pwcc_pkg::res_t      pend_reg, pend_next;

    // Output register.
    pwcc_pkg::res_t      m_res_reg, m_res_next;
    logic                m_last_reg, m_last_next;

    // Slot state memories and their registered read port.
    logic [TAG_W-1:0]    tag_mem   [SLOTS];
    logic [AGE_W-1:0]    age_mem   [SLOTS];
    logic                dirty_mem [SLOTS];
    logic [TAG_W-1:0]    rd_tag_reg;
    logic [AGE_W-1:0]    rd_age_reg;
    logic                rd_dirty_reg;
    logic                rd_valid_reg;

    // Write port.
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [TAG_W-1:0]    wr_tag;
    logic [AGE_W-1:0]    wr_age;
    logic                wr_dirty;

    // Shared datapath signals.
    logic [TAG_W-1:0]    c_tag;
    logic [AGE_W-1:0]    c_age;
    logic                c_dirty;
    logic [PROD_W-1:0]   prod;
    logic [ADDR_W-1:0]   q0_times;
    logic [ADDR_W-1:0]   rem;
    logic [ADDR_W-1:0]   page_calc;
    logic                scan_last;
    logic                out_free;
    logic                page_match;
    logic [AGE_W-1:0]    age_inc;
    logic [IDX_W-1:0]    victim;
    logic                victim_wb;
    logic                is_write;
    logic                push;
    pwcc_pkg::res_t      push_res;
    logic                push_last;
    logic [IDX_W-1:0]    si_idx;
    logic                si_bad;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign scan_last = (idx_reg == LAST_IDX);
    assign is_write = (op_reg == pwcc_pkg::OP_WRITE);
    assign si_idx = s_tdata[16 +: IDX_W];
    assign si_bad = ({1'b0, s_tdata[16 +: SI_W]} >= (SI_W + 1)'(SLOTS));

    // A slot never written since reset reads as empty, age zero, clean.
    assign c_tag   = rd_valid_reg ? rd_tag_reg : pwcc_pkg::EMPTY_TAG;
    assign c_age   = rd_valid_reg ? rd_age_reg : '0;
    assign c_dirty = rd_valid_reg & rd_dirty_reg;

    // Page number: reciprocal estimate, then one compare and correct.
    assign prod      = {{DIV_SH{1'b0}}, addr_reg} * {{ADDR_W{1'b0}}, RECIP};
    assign q0_times  = ADDR_W'(q0_reg * PAGE_SIZE);
    assign rem       = addr_reg - q0_times;
    assign page_calc = (rem >= PAGE_SIZE) ? ADDR_W'(q0_reg + 1'b1) : q0_reg;

    // Shared compare and age units that act on the slot just read.
    assign page_match = (page_reg == ADDR_W'(c_tag));
    assign age_inc = (c_age < max_age_reg) ? AGE_W'(c_age + 1'b1) : c_age;

    // Victim for a miss: first empty, else oldest clean, else slot zero.
    always_comb begin
        victim_wb = 1'b0;
        if (emp_found_reg) begin
            victim = emp_idx_reg;
        end else if (cln_found_reg) begin
            victim = cln_idx_reg;
        end else begin
            victim    = '0;
            victim_wb = 1'b1;
        end
    end

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        max_age_next    = cfg_wr_en ? cfg_wr_data : max_age_reg;
        held_valid_next = held_valid_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        q0_next         = q0_reg;
        page_next       = page_reg;
        idx_next        = idx_reg;
        res_cnt_next    = res_cnt_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_age_next    = hit_age_reg;
        hit_dirty_next  = hit_dirty_reg;
        emp_found_next  = emp_found_reg;
        emp_idx_next    = emp_idx_reg;
        cln_found_next  = cln_found_reg;
        cln_idx_next    = cln_idx_reg;
        cln_age_next    = cln_age_reg;
        tag0_next       = tag0_reg;
        pend_next       = pend_reg;
        wr_en           = 1'b0;
        wr_idx          = idx_reg;
        wr_tag          = c_tag;
        wr_age          = c_age;
        wr_dirty        = c_dirty;
        push            = 1'b0;
        push_res        = pend_reg;
        push_last       = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next         = s_tuser;
                    addr_next       = s_tdata[ADDR_W-1:0];
                    idx_next        = '0;
                    res_cnt_next    = '0;
                    held_valid_next = 1'b0;
                    hit_found_next  = 1'b0;
                    emp_found_next  = 1'b0;
                    cln_found_next  = 1'b0;
                    pend_next       = pwcc_pkg::RES_NONE;
                    case (s_tuser)
                        pwcc_pkg::OP_READ, pwcc_pkg::OP_WRITE,
                        pwcc_pkg::OP_INV_ADDR, pwcc_pkg::OP_AGE_ADDR: begin
                            state_next = ST_DIV;
                        end
                        pwcc_pkg::OP_TICK, pwcc_pkg::OP_INV_ALL,
                        pwcc_pkg::OP_FLUSH_ALL: begin
                            state_next = ST_RD;
                        end
                        pwcc_pkg::OP_INV_SLOT, pwcc_pkg::OP_AGE_SLOT,
                        pwcc_pkg::OP_FLUSH_SLOT: begin
                            if (si_bad) begin
                                pend_next  = pwcc_pkg::RES_IGNORED;
                                state_next = ST_DONE;
                            end else begin
                                idx_next   = si_idx;
                                state_next = ST_RD;
                            end
                        end
                        default: begin
                            pend_next  = pwcc_pkg::RES_IGNORED;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_DIV: begin
                q0_next    = prod[DIV_SH +: ADDR_W];
                state_next = ST_CORR;
            end

            // A reserved page never matches, so every address request on it
            // is ignored without a scan.
            ST_CORR: begin
                page_next = page_calc;
                if (page_calc >= ADDR_W'(pwcc_pkg::EMPTY_TAG)) begin
                    pend_next  = pwcc_pkg::RES_IGNORED;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_RD;
                end
            end

            ST_RD: begin
                state_next = ST_EX;
            end

            ST_EX: begin
                case (op_reg)
                    // Lookup scan, gathering victim candidates on the way.
                    pwcc_pkg::OP_READ, pwcc_pkg::OP_WRITE,
                    pwcc_pkg::OP_INV_ADDR, pwcc_pkg::OP_AGE_ADDR: begin
                        if (page_match && !hit_found_reg) begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = idx_reg;
                            hit_age_next   = c_age;
                            hit_dirty_next = c_dirty;
                        end
                        if ((c_tag == pwcc_pkg::EMPTY_TAG) && !emp_found_reg) begin
                            emp_found_next = 1'b1;
                            emp_idx_next   = idx_reg;
                        end
                        if (!c_dirty && (!cln_found_reg || (c_age >= cln_age_reg))) begin
                            cln_found_next = 1'b1;
                            cln_idx_next   = idx_reg;
                            cln_age_next   = c_age;
                        end
                        if (idx_reg == '0) begin
                            tag0_next = c_tag;
                        end
                        if (scan_last) begin
                            state_next = ST_APPLY;
                        end else begin
                            idx_next   = IDX_W'(idx_reg + 1'b1);
                            state_next = ST_RD;
                        end
                    end

                    // Age every slot; the first dirty slot at the limit is
                    // written back and restarts at age zero.
                    pwcc_pkg::OP_TICK: begin
                        wr_en  = 1'b1;
                        wr_age = age_inc;
                        if (!hit_found_reg && (age_inc == max_age_reg) && c_dirty) begin
                            wr_age         = '0;
                            wr_dirty       = 1'b0;
                            hit_found_next = 1'b1;
                            pend_next      = pwcc_pkg::res_wb(SLOT_W'(idx_reg), c_tag);
                        end
                        if (scan_last) begin
                            state_next = ST_DONE;
                        end else begin
                            idx_next   = IDX_W'(idx_reg + 1'b1);
                            state_next = ST_RD;
                        end
                    end

                    pwcc_pkg::OP_INV_SLOT: begin
                        if (c_dirty) begin
                            pend_next = pwcc_pkg::res_wb(SLOT_W'(idx_reg), c_tag);
                        end
                        wr_en      = 1'b1;
                        wr_tag     = pwcc_pkg::EMPTY_TAG;
                        wr_age     = '0;
                        wr_dirty   = 1'b0;
                        state_next = ST_DONE;
                    end

                    pwcc_pkg::OP_AGE_SLOT: begin
                        wr_en      = 1'b1;
                        wr_age     = max_age_reg;
                        state_next = ST_DONE;
                    end

                    pwcc_pkg::OP_FLUSH_SLOT: begin
                        if (c_dirty) begin
                            pend_next = pwcc_pkg::res_wb(SLOT_W'(idx_reg), c_tag);
                            wr_en     = 1'b1;
                            wr_age    = '0;
                            wr_dirty  = 1'b0;
                        end
                        state_next = ST_DONE;
                    end

                    // Bulk scan: the newest write-back is held back so that
                    // the final one can carry the end mark.
                    pwcc_pkg::OP_INV_ALL, pwcc_pkg::OP_FLUSH_ALL: begin
                        if (c_dirty) begin
                            if (res_cnt_reg == CNT_W'(pwcc_pkg::RES_LIMIT)) begin
                                state_next = ST_DONE;
                            end else if (!held_valid_reg || out_free) begin
                                if (held_valid_reg) begin
                                    push      = 1'b1;
                                    push_last = 1'b0;
                                end
                                pend_next       = pwcc_pkg::res_wb(SLOT_W'(idx_reg), c_tag);
                                held_valid_next = 1'b1;
                                res_cnt_next    = CNT_W'(res_cnt_reg + 1'b1);
                                wr_en           = 1'b1;
                                wr_dirty        = 1'b0;
                                if (op_reg == pwcc_pkg::OP_INV_ALL) begin
                                    wr_tag = pwcc_pkg::EMPTY_TAG;
                                    wr_age = '0;
                                end
                                if (scan_last) begin
                                    state_next = ST_DONE;
                                end else begin
                                    idx_next   = IDX_W'(idx_reg + 1'b1);
                                    state_next = ST_RD;
                                end
                            end
                        end else begin
                            if (op_reg == pwcc_pkg::OP_INV_ALL) begin
                                wr_en    = 1'b1;
                                wr_tag   = pwcc_pkg::EMPTY_TAG;
                                wr_age   = '0;
                                wr_dirty = 1'b0;
                            end
                            if (scan_last) begin
                                state_next = ST_DONE;
                            end else begin
                                idx_next   = IDX_W'(idx_reg + 1'b1);
                                state_next = ST_RD;
                            end
                        end
                    end

                    default: begin
                        pend_next  = pwcc_pkg::RES_IGNORED;
                        state_next = ST_DONE;
                    end
                endcase
            end

            // Update the slot chosen by the lookup scan.
            ST_APPLY: begin
                state_next = ST_DONE;
                case (op_reg)
                    pwcc_pkg::OP_READ, pwcc_pkg::OP_WRITE: begin
                        wr_en  = 1'b1;
                        wr_tag = page_reg[TAG_W-1:0];
                        if (hit_found_reg) begin
                            wr_idx   = hit_idx_reg;
                            wr_age   = (!is_write && !hit_dirty_reg) ? '0 : hit_age_reg;
                            wr_dirty = is_write | hit_dirty_reg;
                        end else begin
                            wr_idx   = victim;
                            wr_age   = '0;
                            wr_dirty = is_write;
                        end
                        pend_next                 = pwcc_pkg::RES_NONE;
                        pend_next.hit             = hit_found_reg;
                        pend_next.access_slot     = SLOT_W'(wr_idx);
                        pend_next.fill_valid      = !hit_found_reg;
                        pend_next.writeback_valid = !hit_found_reg && victim_wb;
                        pend_next.writeback_page  = (!hit_found_reg && victim_wb) ?
                                                    tag0_reg : '0;
                    end
                    pwcc_pkg::OP_INV_ADDR: begin
                        if (!hit_found_reg) begin
                            pend_next = pwcc_pkg::RES_IGNORED;
                        end else begin
                            if (hit_dirty_reg) begin
                                pend_next = pwcc_pkg::res_wb(SLOT_W'(hit_idx_reg),
                                                             page_reg[TAG_W-1:0]);
                            end
                            wr_en    = 1'b1;
                            wr_idx   = hit_idx_reg;
                            wr_tag   = pwcc_pkg::EMPTY_TAG;
                            wr_age   = '0;
                            wr_dirty = 1'b0;
                        end
                    end
                    pwcc_pkg::OP_AGE_ADDR: begin
                        if (!hit_found_reg) begin
                            pend_next = pwcc_pkg::RES_IGNORED;
                        end else begin
                            wr_en    = 1'b1;
                            wr_idx   = hit_idx_reg;
                            wr_tag   = page_reg[TAG_W-1:0];
                            wr_age   = max_age_reg;
                            wr_dirty = hit_dirty_reg;
                        end
                    end
                    default: begin
                        pend_next = pwcc_pkg::RES_IGNORED;
                    end
                endcase
            end

            // Hand the final result to the output register.
            ST_DONE: begin
                if (out_free) begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Slot valid flags follow the write port.
    always_comb begin
        ent_valid_next = ent_valid_reg;
        if (wr_en) begin
            ent_valid_next[wr_idx] = 1'b1;
        end
    end

    // Output register: loads on a push, empties when the receiver takes it.
    always_comb begin
        m_res_next  = m_res_reg;
        m_last_next = m_last_reg;
        if (push) begin
            m_valid_next = 1'b1;
            m_res_next   = push_res;
            m_last_next  = push_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            max_age_reg    <= pwcc_pkg::MAX_AGE_RESET;
            ent_valid_reg  <= '0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            max_age_reg    <= max_age_next;
            ent_valid_reg  <= ent_valid_next;
            held_valid_reg <= held_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Request, scan and result payload registers.
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        addr_reg      <= addr_next;
        q0_reg        <= q0_next;
        page_reg      <= page_next;
        idx_reg       <= idx_next;
        res_cnt_reg   <= res_cnt_next;
        hit_found_reg <= hit_found_next;
        hit_idx_reg   <= hit_idx_next;
        hit_age_reg   <= hit_age_next;
        hit_dirty_reg <= hit_dirty_next;
        emp_found_reg <= emp_found_next;
        emp_idx_reg   <= emp_idx_next;
        cln_found_reg <= cln_found_next;
        cln_idx_reg   <= cln_idx_next;
        cln_age_reg   <= cln_age_next;
        tag0_reg      <= tag0_next;
        pend_reg      <= pend_next;
        m_res_reg     <= m_res_next;
        m_last_reg    <= m_last_next;
    end

    // Slot memories: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tag_mem[wr_idx]   <= wr_tag;
            age_mem[wr_idx]   <= wr_age;
            dirty_mem[wr_idx] <= wr_dirty;
        end
        rd_tag_reg   <= tag_mem[idx_reg];
        rd_age_reg   <= age_mem[idx_reg];
        rd_dirty_reg <= dirty_mem[idx_reg];
        rd_valid_reg <= ent_valid_reg[idx_reg];
    end

    // Result stream packing.
    assign m_tvalid   = m_valid_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_res_reg.status;
    assign m_tdata    = {5'b0,
                         m_res_reg.writeback_page,
                         m_res_reg.writeback_slot,
                         m_res_reg.writeback_valid,
                         m_res_reg.fill_valid,
                         m_res_reg.access_slot,
                         m_res_reg.hit};

    // A request is taken only while idle, so the next cycle is busy.
    `PWCC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // Write-back slot and page are zero whenever no write-back is reported.
    `PWCC_ASSERT_NOW(a_wb_fields_clear, aclk, aresetn, m_tvalid && !m_tdata[5], m_tdata[18:6] == 13'd0)
    // A fill only follows a miss on a request that was carried out.
    `PWCC_ASSERT_NOW(a_fill_on_miss, aclk, aresetn, m_tvalid && m_tdata[4], !m_tdata[0] && !m_tuser[0])
    // Bulk scans never report more than the result limit.
    `PWCC_ASSERT_NOW(a_res_limit, aclk, aresetn, held_valid_reg, res_cnt_reg <= CNT_W'(pwcc_pkg::RES_LIMIT))

endmodule

[tb/tb_page_writeback_cache_controller.sv]
// Self-checking testbench of the page write-back cache controller.
module tb_page_writeback_cache_controller;

    import pwcc_pkg::*;

    localparam int NSLOTS = SLOTS_DEF;
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 4'd10;
    localparam logic [OP_W-1:0] OP_LAST_CODE    = 4'd15;

    // One expected or observed result, with its end-of-request mark.
    typedef struct packed {
        res_t r;
        logic last;
    } cache_result_t;

    // Slot bookkeeping of the cache and the results that it owes.
    class cache_scoreboard;
        logic [TAG_W-1:0] slot_page [NSLOTS];
        logic [AGE_W-1:0] slot_age [NSLOTS];
        bit               slot_dirty [NSLOTS];
        logic [AGE_W-1:0] age_limit;
        cache_result_t    expected_q [$];
        res_t             batch [$];
        int               mismatches;

        function void reset_state();
            for (int i = 0; i < NSLOTS; i++) begin
                slot_page[i]  = EMPTY_TAG;
                slot_age[i]   = '0;
                slot_dirty[i] = 1'b0;
            end
            age_limit = MAX_AGE_RESET;
            expected_q.delete();
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Lowest slot holding the page; NSLOTS on a miss or a reserved page.
        function int find_page(logic [TAG_W-1:0] page);
            if (page == EMPTY_TAG) return NSLOTS;
            for (int i = 0; i < NSLOTS; i++)
                if (slot_page[i] == page) return i;
            return NSLOTS;
        endfunction

        function res_t writeback_of(int s);
            res_t r;
            r                 = RES_NONE;
            r.writeback_valid = 1'b1;
            r.writeback_slot  = SLOT_W'(s);
            r.writeback_page  = slot_page[s];
            return r;
        endfunction

        // Empties a slot, reporting its write-back if it was dirty.
        function void invalidate_slot(int s);
            batch.push_back(slot_dirty[s] ? writeback_of(s) : RES_NONE);
            slot_page[s]  = EMPTY_TAG;
            slot_age[s]   = '0;
            slot_dirty[s] = 1'b0;
        endfunction

        // Applies one accepted request and queues the results it causes.
        function void note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                   logic [SI_W-1:0] si);
            logic [TAG_W-1:0] page;
            logic [AGE_W-1:0] best_age;
            int               s;
            bit               found;
            bit               stopped;
            res_t             r;
            cache_result_t    e;

            batch.delete();
            page = TAG_W'(addr / PAGE_BYTES_DEF);
            case (op)
                OP_READ, OP_WRITE: begin
                    if (page == EMPTY_TAG) begin
                        batch.push_back(RES_IGNORED);
                    end else begin
                        r = RES_NONE;
                        s = find_page(page);
                        if (s < NSLOTS) begin
                            r.hit = 1'b1;
                        end else begin
                            // First empty slot, else oldest clean, else slot 0.
                            for (int i = 0; i < NSLOTS && s == NSLOTS; i++)
                                if (slot_page[i] == EMPTY_TAG) s = i;
                            if (s == NSLOTS) begin
                                best_age = '0;
                                for (int i = 0; i < NSLOTS; i++) begin
                                    if (!slot_dirty[i] && slot_age[i] >= best_age) begin
                                        s        = i;
                                        best_age = slot_age[i];
                                    end
                                end
                            end
                            if (s == NSLOTS) begin
                                r = writeback_of(0);
                                s = 0;
                            end
                            r.fill_valid  = 1'b1;
                            slot_page[s]  = page;
                            slot_age[s]   = '0;
                            slot_dirty[s] = 1'b0;
                        end
                        if (op == OP_WRITE) slot_dirty[s] = 1'b1;
                        else if (!slot_dirty[s]) slot_age[s] = '0;
                        r.access_slot = SLOT_W'(s);
                        batch.push_back(r);
                    end
                end
                OP_TICK: begin
                    for (int i = 0; i < NSLOTS; i++)
                        if (slot_age[i] < age_limit) slot_age[i]++;
                    r     = RES_NONE;
                    found = 1'b0;
                    for (int i = 0; i < NSLOTS; i++) begin
                        if (!found && slot_age[i] == age_limit && slot_dirty[i]) begin
                            r             = writeback_of(i);
                            slot_dirty[i] = 1'b0;
                            slot_age[i]   = '0;
                            found         = 1'b1;
                        end
                    end
                    batch.push_back(r);
                end
                OP_INV_ADDR, OP_AGE_ADDR: begin
                    s = find_page(page);
                    if (s >= NSLOTS) begin
                        batch.push_back(RES_IGNORED);
                    end else if (op == OP_INV_ADDR) begin
                        invalidate_slot(s);
                    end else begin
                        slot_age[s] = age_limit;
                        batch.push_back(RES_NONE);
                    end
                end
                OP_INV_SLOT, OP_AGE_SLOT, OP_FLUSH_SLOT: begin
                    if (si >= NSLOTS) begin
                        batch.push_back(RES_IGNORED);
                    end else if (op == OP_INV_SLOT) begin
                        invalidate_slot(si);
                    end else if (op == OP_AGE_SLOT) begin
                        slot_age[si] = age_limit;
                        batch.push_back(RES_NONE);
                    end else if (slot_dirty[si]) begin
                        batch.push_back(writeback_of(si));
                        slot_dirty[si] = 1'b0;
                        slot_age[si]   = '0;
                    end else begin
                        batch.push_back(RES_NONE);
                    end
                end
                OP_INV_ALL, OP_FLUSH_ALL: begin
                    // A dirty slot past the result limit stops the scan there.
                    stopped = 1'b0;
                    for (int i = 0; i < NSLOTS && !stopped; i++) begin
                        if (slot_dirty[i]) begin
                            if (batch.size() >= RES_LIMIT) begin
                                stopped = 1'b1;
                            end else begin
                                batch.push_back(writeback_of(i));
                                slot_dirty[i] = 1'b0;
                            end
                        end
                        if (!stopped && op == OP_INV_ALL) begin
                            slot_page[i] = EMPTY_TAG;
                            slot_age[i]  = '0;
                        end
                    end
                    if (batch.size() == 0) batch.push_back(RES_NONE);
                end
                default: begin
                    batch.push_back(RES_IGNORED);
                end
            endcase

            foreach (batch[k]) begin
                e.r    = batch[k];
                e.last = (k == batch.size() - 1);
                expected_q.push_back(e);
            end
        endfunction

        function string describe(cache_result_t c);
            return $sformatf({"status=%0d hit=%0d slot=%0d fill=%0d wb=%0d ",
                              "wb_slot=%0d wb_page=%0d last=%0d"},
                             c.r.status, c.r.hit, c.r.access_slot, c.r.fill_valid,
                             c.r.writeback_valid, c.r.writeback_slot,
                             c.r.writeback_page, c.last);
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(logic status, logic [23:0] data, logic last);
            cache_result_t got;
            cache_result_t want;

            got.r.status          = status;
            got.r.hit             = data[0];
            got.r.access_slot     = data[3:1];
            got.r.fill_valid      = data[4];
            got.r.writeback_valid = data[5];
            got.r.writeback_slot  = data[8:6];
            got.r.writeback_page  = data[18:9];
            got.last              = last;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got %s",
                         $time, describe(got));
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: result mismatch, expected %s, got %s",
                             $time, describe(want), describe(got));
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;

    cache_scoreboard sb;
    bit              gaps_on;
    logic [AGE_W-1:0] age_settings [6] = '{8'd3, 8'd1, 8'd255, 8'd0, 8'd8, 8'd32};

    page_writeback_cache_controller u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Overall time limit of the run.
    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    // Offers one request after a random gap and waits until it is taken.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                input logic [SI_W-1:0] si);
        int gap;
        @(negedge aclk);
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, si, addr};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, addr, si);
    endtask

    task automatic go_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Writes the age limit once the block has answered every request.
    task automatic set_max_age(input logic [AGE_W-1:0] value);
        go_idle();
        while (sb.pending() != 0) @(negedge aclk);
        repeat (2 * NSLOTS + 8) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        sb.age_limit  = value;
    endtask

    // Random request, mostly accesses to a small set of pages so that slots thrash.
    task automatic send_random_request();
        int                pick;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [SI_W-1:0]   si;
        pick = $urandom_range(0, 99);
        if (pick < 30)      op = OP_READ;
        else if (pick < 55) op = OP_WRITE;
        else if (pick < 67) op = OP_TICK;
        else if (pick < 71) op = OP_INV_ADDR;
        else if (pick < 75) op = OP_INV_SLOT;
        else if (pick < 79) op = OP_AGE_ADDR;
        else if (pick < 83) op = OP_AGE_SLOT;
        else if (pick < 88) op = OP_FLUSH_SLOT;
        else if (pick < 91) op = OP_INV_ALL;
        else if (pick < 94) op = OP_FLUSH_ALL;
        else                op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
        pick = $urandom_range(0, 99);
        if (pick < 80)
            addr = {TAG_W'($urandom_range(0, 11) * 85), 6'($urandom)};
        else if (pick < 95)
            addr = ADDR_W'($urandom_range(0, 65535));
        else
            addr = ADDR_W'($urandom_range(65472, 65535));
        si = ($urandom_range(0, 3) == 0) ? SI_W'($urandom_range(0, 63))
                                         : SI_W'($urandom_range(0, NSLOTS - 1));
        send_request(op, addr, si);
    endtask

    // Result side: random stall before each result.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            stall = gaps_on ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser[0], m_tdata, m_tlast);
    end

    // Main sequence: reset, directed requests, then random phases.
    initial begin
        sb = new;
        sb.reset_state();
        gaps_on     = 1'b1;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Fills, a hit, reserved pages and unknown operations.
        send_request(OP_READ, 16'h0000, 6'd0);
        send_request(OP_WRITE, 16'hFFBF, 6'd63);
        send_request(OP_READ, 16'h0010, 6'd0);
        send_request(OP_READ, 16'hFFC0, 6'd0);
        send_request(OP_WRITE, 16'hFFFF, 6'd0);
        send_request(OP_FIRST_UNUSED, 16'h0000, 6'd0);
        send_request(OP_LAST_CODE, 16'hFFFF, 6'd63);
        // Fill the rest, then evict the clean slot, then a dirty one.
        for (int p = 2; p < NSLOTS; p++)
            send_request(OP_WRITE, ADDR_W'(p * PAGE_BYTES_DEF), 6'd0);
        send_request(OP_WRITE, 16'h0200, 6'd0);
        send_request(OP_WRITE, 16'h0240, 6'd0);
        // Aging, invalidation and flushing, including misses and bad slots.
        send_request(OP_AGE_SLOT, 16'h0000, 6'd3);
        send_request(OP_TICK, 16'h0000, 6'd0);
        send_request(OP_AGE_ADDR, 16'h7D00, 6'd0);
        send_request(OP_AGE_ADDR, 16'hFFBF, 6'd0);
        send_request(OP_INV_ADDR, 16'hFFBF, 6'd0);
        send_request(OP_INV_SLOT, 16'h0000, 6'd63);
        send_request(OP_INV_SLOT, 16'h0000, 6'd2);
        send_request(OP_FLUSH_SLOT, 16'h0000, 6'd4);
        send_request(OP_FLUSH_SLOT, 16'h0000, 6'd4);
        send_request(OP_FLUSH_SLOT, 16'h0000, 6'd9);
        send_request(OP_AGE_SLOT, 16'h0000, 6'd8);
        send_request(OP_FLUSH_ALL, 16'h0000, 6'd0);
        send_request(OP_INV_ALL, 16'h0000, 6'd0);
        send_request(OP_FLUSH_ALL, 16'h0000, 6'd0);

        // Random phases, each with its own age limit; one runs without idling.
        for (int ph = 0; ph < 6; ph++) begin
            set_max_age(age_settings[ph]);
            gaps_on = (ph != 2);
            repeat (38) send_random_request();
        end

        go_idle();
        while (sb.pending() != 0) @(negedge aclk);
        repeat (2 * NSLOTS + 10) @(negedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/pwcc_pkg.sv
hw/rtl/page_writeback_cache_controller.sv
tb/tb_page_writeback_cache_controller.sv
